// ----- rtl/core/gcrb_pkg.sv -----
// ----------------------------------------------------------------------------
// gcrb_pkg: shared types and constants for the range and bearing pipeline
// Fixed-point formats, CORDIC step angles and unit latencies used by the
// great-circle range and bearing block and its arithmetic units.
// ----------------------------------------------------------------------------
package gcrb_pkg;

  localparam int CORDIC_STEPS    = 31;
  localparam int ITERS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = (CORDIC_STEPS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;

  // prep register, iteration stages, output register
  localparam int SINCOS_LAT = CORDIC_STAGES + 2;
  localparam int VEC_LAT    = CORDIC_STAGES + 2;

  localparam int SQRT_PAIRS  = 32;
  localparam int SQRT_STAGES = SQRT_PAIRS / 2;
  localparam int SQRT_LAT    = SQRT_STAGES + 1;

  // input register, reciprocal product, table and add, sign
  localparam int DIV_LAT = 4;

  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;
  localparam logic        [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic        [33:0] PI_TURN      = 34'd13493037705;
  localparam logic        [25:0] RANGE_MAX    = 26'h3FF_FFFF;
  localparam logic        [23:0] RADIUS_RESET = 24'd6371000;

  typedef logic signed [31:0] q30_t;
  typedef logic        [31:0] turn_t;

  typedef struct packed {
    q30_t c;
    q30_t s;
  } sincos_t;

  typedef struct packed {
    logic [25:0] distance;
    logic [24:0] brg;
  } result_t;

  // atan(2^-i) in turns scaled by 2^32
  function automatic turn_t step_angle(input int i);
    case (i)
      0:       step_angle = 32'h2000_0000;
      1:       step_angle = 32'h12E4_051E;
      2:       step_angle = 32'h09FB_385B;
      3:       step_angle = 32'h0511_11D4;
      4:       step_angle = 32'h028B_0D43;
      5:       step_angle = 32'h0145_D7E1;
      6:       step_angle = 32'h00A2_F61E;
      7:       step_angle = 32'h0051_7C55;
      8:       step_angle = 32'h0028_BE53;
      9:       step_angle = 32'h0014_5F2F;
      10:      step_angle = 32'h000A_2F98;
      11:      step_angle = 32'h0005_17CC;
      12:      step_angle = 32'h0002_8BE6;
      13:      step_angle = 32'h0001_45F3;
      14:      step_angle = 32'h0000_A2FA;
      15:      step_angle = 32'h0000_517D;
      16:      step_angle = 32'h0000_28BE;
      17:      step_angle = 32'h0000_145F;
      18:      step_angle = 32'h0000_0A30;
      19:      step_angle = 32'h0000_0518;
      20:      step_angle = 32'h0000_028C;
      21:      step_angle = 32'h0000_0146;
      22:      step_angle = 32'h0000_00A3;
      23:      step_angle = 32'h0000_0051;
      24:      step_angle = 32'h0000_0029;
      25:      step_angle = 32'h0000_0014;
      26:      step_angle = 32'h0000_000A;
      27:      step_angle = 32'h0000_0005;
      28:      step_angle = 32'h0000_0003;
      29:      step_angle = 32'h0000_0001;
      30:      step_angle = 32'h0000_0001;
      default: step_angle = 32'h0000_0000;
    endcase
  endfunction

endpackage

// ----- rtl/core/great_circle_range_bearing.sv -----
// ----------------------------------------------------------------------------
// great_circle_range_bearing: haversine range and initial bearing
// Fully pipelined: divide-by-360 angle conversion, five rotation CORDICs,
// Q30 products, two square roots, two vectoring CORDICs and final scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one position pair per beat:
//   start and end latitude/longitude in signed degrees times 2^F.
//   Output channel (out_valid/out_ready) carries range_out, the haversine
//   distance in earth_radius units, and bearing_out, degrees times 2^F.
//   cfg_write/cfg_data load earth_radius; write only while the block is idle.
//   The delay from input beat to output valid is the same for any F; it is
//   set by the 16-stage CORDICs, the square root, the four-stage angle
//   conversion, the product and scaling stages and the output queue write.
//   Throughput is one pair per cycle while out_ready is high.
//   A two-entry output queue takes results; the whole pipeline holds only
//   when that queue is full, so in_ready drops once the queue fills after
//   out_ready stops taking results, and nothing is dropped or repeated.
//   Reset clears all valid bits and the queue and loads earth_radius with
//   6371000.
// ----------------------------------------------------------------------------
module great_circle_range_bearing #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] start_lat,
  input  logic signed [24:0] start_lon,
  input  logic signed [23:0] end_lat,
  input  logic signed [24:0] end_lon,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [25:0]        range_out,
  output logic [24:0]        bearing_out
);

  localparam int S        = 32 - ANGLE_FRAC_BITS;
  localparam int DIV_LAT  = gcrb_pkg::DIV_LAT;
  localparam int SQ_LAT   = gcrb_pkg::SQRT_LAT;
  localparam int FLAG_DLY = gcrb_pkg::SINCOS_LAT + 3 + SQ_LAT + gcrb_pkg::VEC_LAT;
  localparam int LAT      = DIV_LAT + gcrb_pkg::SINCOS_LAT + 3 + SQ_LAT
                            + gcrb_pkg::VEC_LAT + 4;
  localparam logic [40:0] BRG_RND  = 41'd1 << (31 - ANGLE_FRAC_BITS);
  localparam logic [40:0] BRG_FULL = 41'd360 << ANGLE_FRAC_BITS;

  function automatic gcrb_pkg::q30_t mulq(input gcrb_pkg::q30_t a, input gcrb_pkg::q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    mulq = 32'(p >>> 30);
  endfunction

  logic en;
  logic [23:0] radius;
  logic vld [LAT];

  // output queue
  gcrb_pkg::result_t q0, q1;
  logic [1:0] count;
  logic push, pop;

  assign en        = (count != 2'd2);
  assign in_ready  = en;
  assign out_valid = (count != 2'd0);
  assign range_out = q0.distance;
  assign bearing_out = q0.brg;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcrb_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // ---- angle conversion ----
  logic signed [25:0] lat1_w, lat2_w, dlat_w, dlon_w;
  gcrb_pkg::turn_t t_lat1, t_lat2, t_dlon, t_hlat, t_hlon;

  assign lat1_w = 26'(start_lat);
  assign lat2_w = 26'(end_lat);
  assign dlat_w = 26'(end_lat) - 26'(start_lat);
  assign dlon_w = 26'(end_lon) - 26'(start_lon);

  gcrb_div360 #(.SHIFT(S))     u_div_lat1 (.clk, .en, .v(lat1_w), .r(t_lat1));
  gcrb_div360 #(.SHIFT(S))     u_div_lat2 (.clk, .en, .v(lat2_w), .r(t_lat2));
  gcrb_div360 #(.SHIFT(S))     u_div_dlon (.clk, .en, .v(dlon_w), .r(t_dlon));
  gcrb_div360 #(.SHIFT(S - 1)) u_div_hlat (.clk, .en, .v(dlat_w), .r(t_hlat));
  gcrb_div360 #(.SHIFT(S - 1)) u_div_hlon (.clk, .en, .v(dlon_w), .r(t_hlon));

  // same-point flag travels beside the data
  logic lat_eq_d [DIV_LAT];
  logic flag_d   [FLAG_DLY];
  logic same_pt;

  assign same_pt = lat_eq_d[DIV_LAT-1] && (t_dlon == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      lat_eq_d[0] <= (start_lat == end_lat);
      for (int i = 1; i < DIV_LAT; i++) lat_eq_d[i] <= lat_eq_d[i-1];
      flag_d[0] <= same_pt;
      for (int i = 1; i < FLAG_DLY; i++) flag_d[i] <= flag_d[i-1];
    end
  end

  // ---- sine and cosine ----
  gcrb_pkg::sincos_t cs1, cs2, csdl, cshl, cshn;

  gcrb_sincos u_sc_lat1 (.clk, .en, .t(t_lat1), .cs(cs1));
  gcrb_sincos u_sc_lat2 (.clk, .en, .t(t_lat2), .cs(cs2));
  gcrb_sincos u_sc_dlon (.clk, .en, .t(t_dlon), .cs(csdl));
  gcrb_sincos u_sc_hlat (.clk, .en, .t(t_hlat), .cs(cshl));
  gcrb_sincos u_sc_hlon (.clk, .en, .t(t_hlon), .cs(cshn));

  // ---- products ----
  gcrb_pkg::q30_t shl2_p1, c1c2_p1, shn2_p1, by_p1, c1s2_p1, s1c2_p1, cdl_p1;
  gcrb_pkg::q30_t shl2_p2, hav_p2, by_p2, c1s2_p2, s1c2cdl_p2;
  logic signed [32:0] a_sum;
  logic [30:0]        a_p3;
  logic signed [33:0] bx_p3, by_p3;

  assign a_sum = 33'(shl2_p2) + 33'(hav_p2);

  always_ff @(posedge clk) begin
    if (en) begin
      shl2_p1 <= mulq(cshl.s, cshl.s);
      c1c2_p1 <= mulq(cs1.c, cs2.c);
      shn2_p1 <= mulq(cshn.s, cshn.s);
      by_p1   <= mulq(csdl.s, cs2.c);
      c1s2_p1 <= mulq(cs1.c, cs2.s);
      s1c2_p1 <= mulq(cs1.s, cs2.c);
      cdl_p1  <= csdl.c;

      shl2_p2    <= shl2_p1;
      hav_p2     <= mulq(c1c2_p1, shn2_p1);
      by_p2      <= by_p1;
      c1s2_p2    <= c1s2_p1;
      s1c2cdl_p2 <= mulq(s1c2_p1, cdl_p1);

      // clamp into [0, 1]
      if (a_sum < 0) begin
        a_p3 <= '0;
      end else if (a_sum > $signed({2'b00, gcrb_pkg::ONE_Q30})) begin
        a_p3 <= gcrb_pkg::ONE_Q30;
      end else begin
        a_p3 <= a_sum[30:0];
      end
      bx_p3 <= 34'(c1s2_p2) - 34'(s1c2cdl_p2);
      by_p3 <= 34'(by_p2);
    end
  end

  // ---- square roots, with the bearing vector held alongside ----
  logic [30:0] asq, bsq;
  logic signed [33:0] bx_d [SQ_LAT];
  logic signed [33:0] by_d [SQ_LAT];

  gcrb_sqrt u_sqrt_a (.clk, .en, .a(a_p3), .root_out(asq));
  gcrb_sqrt u_sqrt_b (.clk, .en, .a(gcrb_pkg::ONE_Q30 - a_p3), .root_out(bsq));

  always_ff @(posedge clk) begin
    if (en) begin
      bx_d[0] <= bx_p3;
      by_d[0] <= by_p3;
      for (int i = 1; i < SQ_LAT; i++) begin
        bx_d[i] <= bx_d[i-1];
        by_d[i] <= by_d[i-1];
      end
    end
  end

  // ---- angles ----
  gcrb_pkg::turn_t half, brg;

  gcrb_vec u_vec_dist (.clk, .en, .x_in(34'(bsq)), .y_in(34'(asq)), .ang(half));
  gcrb_vec u_vec_brg  (.clk, .en, .x_in(bx_d[SQ_LAT-1]), .y_in(by_d[SQ_LAT-1]), .ang(brg));

  // ---- scaling ----
  logic [55:0] rh_f1;
  logic [40:0] bmul_f1;
  logic        flag_f1;
  logic [61:0] phi_f2, plo_f2;
  logic [24:0] deg_f2, deg_f3, deg_f4;
  logic [91:0] sum_f3;
  logic [25:0] dist_f4;
  logic [40:0] deg_sh;
  logic [29:0] dist_w;

  assign deg_sh = bmul_f1 >> S;
  assign dist_w = sum_f3[91:62];

  always_ff @(posedge clk) begin
    if (en) begin
      rh_f1   <= 56'(radius) * 56'(half);
      bmul_f1 <= 41'(brg) * 41'd360 + BRG_RND;
      flag_f1 <= flag_d[FLAG_DLY-1];

      phi_f2 <= 62'(rh_f1[55:28]) * 62'(gcrb_pkg::PI_TURN);
      plo_f2 <= 62'(rh_f1[27:0]) * 62'(gcrb_pkg::PI_TURN);
      // zero for the same point; fold a bearing that rounds to a full turn back to zero
      if (flag_f1) begin
        deg_f2 <= '0;
      end else if (deg_sh >= BRG_FULL) begin
        deg_f2 <= 25'(deg_sh - BRG_FULL);
      end else begin
        deg_f2 <= deg_sh[24:0];
      end

      sum_f3 <= (92'(phi_f2) << 28) + 92'(plo_f2) + (92'd1 << 61);
      deg_f3 <= deg_f2;

      dist_f4 <= (dist_w > 30'(gcrb_pkg::RANGE_MAX)) ? gcrb_pkg::RANGE_MAX : dist_w[25:0];
      deg_f4  <= deg_f3;
    end
  end

  // ---- output queue ----
  gcrb_pkg::result_t res;

  assign res.distance = dist_f4;
  assign res.brg      = deg_f4;
  assign push = en && vld[LAT-1];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) q0 <= res;
      else               q1 <= res;
    end else if (pop && !push) begin
      q0 <= q1;
    end else if (push && pop) begin
      // one entry held and leaving: replace it
      q0 <= res;
    end
  end

endmodule

// ----- rtl/core/gcrb_div360.sv -----
// ----------------------------------------------------------------------------
// gcrb_div360: degrees to turns conversion
// Four-stage pipeline giving round(|v| * 2^SHIFT / 360) modulo 2^32, negated
// for negative v: split |v| by 45 with a reciprocal product, then add the
// scaled quotient to a small table entry for the remainder.
// ----------------------------------------------------------------------------
module gcrb_div360 #(
  parameter int SHIFT = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [25:0]   v,
  output gcrb_pkg::turn_t      r
);

  // floor(m / 45) = (m * RECIP) >> 32, exact for every 26-bit m
  localparam logic [26:0] RECIP = 27'd95443718;

  logic [25:0] mag;
  logic [25:0] mag_a, mag_b;
  logic        neg_a, neg_b, neg_c;
  logic [52:0] prod;
  logic [20:0] u_b;
  logic [25:0] rem_w;
  logic [5:0]  w;
  logic [31:0] tab [45];
  logic [31:0] quo_c;

  assign mag   = v[25] ? 26'(-v) : 26'(v);
  assign prod  = 53'(mag_a) * 53'(RECIP);
  assign rem_w = mag_b - 26'(u_b) * 26'd45;
  assign w     = rem_w[5:0];

  // (w * 2^SHIFT + 180) / 360 for each remainder w of the split by 45
  for (genvar i = 0; i < 45; i++) begin : g_tab
    localparam logic [31:0] FRAC = 32'(((64'(i) << SHIFT) + 64'd180) / 64'd360);
    assign tab[i] = FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= v[25];
      mag_a <= mag;

      neg_b <= neg_a;
      mag_b <= mag_a;
      u_b   <= prod[52:32];

      // 45 * 2^SHIFT / 360 = 2^(SHIFT-3)
      neg_c <= neg_b;
      quo_c <= 32'((64'(u_b) << (SHIFT - 3)) + 64'(tab[w]));

      r <= neg_c ? -quo_c : quo_c;
    end
  end

endmodule

// ----- rtl/core/gcrb_sincos.sv -----
// ----------------------------------------------------------------------------
// gcrb_sincos: pipelined rotation CORDIC
// Cosine and sine in Q30 of an angle in turns scaled by 2^32, two
// iterations per stage.
// ----------------------------------------------------------------------------
module gcrb_sincos (
  input  logic              clk,
  input  logic              en,
  input  gcrb_pkg::turn_t   t,
  output gcrb_pkg::sincos_t cs
);

  localparam int NS  = gcrb_pkg::CORDIC_STAGES;
  localparam int IPS = gcrb_pkg::ITERS_PER_STAGE;

  logic signed [31:0] x [NS+1];
  logic signed [31:0] y [NS+1];
  logic signed [31:0] z [NS+1];
  logic               flip [NS+1];
  gcrb_pkg::turn_t    t_sh;
  gcrb_pkg::turn_t    t_half;

  assign t_sh   = t + 32'h4000_0000;
  assign t_half = t + 32'h8000_0000;

  // outside the right half plane: turn by half a turn, negate at the end
  always_ff @(posedge clk) begin
    if (en) begin
      flip[0] <= t_sh[31];
      x[0]    <= gcrb_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= t_sh[31] ? $signed(t_half) : $signed(t);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [31:0] xn, yn, zn;

    always_comb begin
      int i;
      logic signed [31:0] xt;
      xn = x[k];
      yn = y[k];
      zn = z[k];
      for (int j = 0; j < IPS; j++) begin
        i = k * IPS + j;
        if (i < gcrb_pkg::CORDIC_STEPS) begin
          if (zn >= 0) begin
            xt = xn - (yn >>> i);
            yn = yn + (xn >>> i);
            zn = zn - $signed(gcrb_pkg::step_angle(i));
          end else begin
            xt = xn + (yn >>> i);
            yn = yn - (xn >>> i);
            zn = zn + $signed(gcrb_pkg::step_angle(i));
          end
          xn = xt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[k+1]    <= xn;
        y[k+1]    <= yn;
        z[k+1]    <= zn;
        flip[k+1] <= flip[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs.c <= flip[NS] ? -x[NS] : x[NS];
      cs.s <= flip[NS] ? -y[NS] : y[NS];
    end
  end

endmodule

// ----- rtl/core/gcrb_vec.sv -----
// ----------------------------------------------------------------------------
// gcrb_vec: pipelined vectoring CORDIC
// Angle of the vector (x, y) in turns scaled by 2^32, two iterations per
// stage; the zero vector gives angle zero.
// ----------------------------------------------------------------------------
module gcrb_vec (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  output gcrb_pkg::turn_t    ang
);

  localparam int NS  = gcrb_pkg::CORDIC_STAGES;
  localparam int IPS = gcrb_pkg::ITERS_PER_STAGE;
  localparam logic signed [33:0] HALF_TURN = 34'sh0_8000_0000;

  logic signed [35:0] x [NS+1];
  logic signed [35:0] y [NS+1];
  logic signed [33:0] z [NS+1];
  logic               zero [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
        x[0] <= -36'(x_in);
        y[0] <= -36'(y_in);
        z[0] <= HALF_TURN;
      end else begin
        x[0] <= 36'(x_in);
        y[0] <= 36'(y_in);
        z[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [35:0] xn, yn;
    logic signed [33:0] zn;

    always_comb begin
      int i;
      logic signed [35:0] xt;
      xn = x[k];
      yn = y[k];
      zn = z[k];
      for (int j = 0; j < IPS; j++) begin
        i = k * IPS + j;
        if (i < gcrb_pkg::CORDIC_STEPS) begin
          if (yn >= 0) begin
            xt = xn + (yn >>> i);
            yn = yn - (xn >>> i);
            zn = zn + $signed(34'(gcrb_pkg::step_angle(i)));
          end else begin
            xt = xn - (yn >>> i);
            yn = yn + (xn >>> i);
            zn = zn - $signed(34'(gcrb_pkg::step_angle(i)));
          end
          xn = xt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[k+1]    <= xn;
        y[k+1]    <= yn;
        z[k+1]    <= zn;
        zero[k+1] <= zero[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= zero[NS] ? '0 : z[NS][31:0];
    end
  end

endmodule

// ----- rtl/core/gcrb_sqrt.sv -----
// ----------------------------------------------------------------------------
// gcrb_sqrt: pipelined integer square root
// Floor square root of a Q30 value taken as Q60, giving Q30; two root bits
// per stage.
// ----------------------------------------------------------------------------
module gcrb_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] a,
  output logic [30:0] root_out
);

  localparam int NS = gcrb_pkg::SQRT_STAGES;

  logic [63:0] val  [NS+1];
  logic [35:0] rem  [NS+1];
  logic [31:0] root [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      val[0]  <= {3'b000, a, 30'd0};
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [63:0] vn;
    logic [35:0] rn;
    logic [31:0] qn;

    always_comb begin
      logic [35:0] rv;
      logic [35:0] trial;
      vn = val[k];
      rn = rem[k];
      qn = root[k];
      for (int j = 0; j < 2; j++) begin
        rv    = {rn[33:0], vn[63:62]};
        trial = {2'b00, qn, 2'b01};
        if (rv >= trial) begin
          rn = rv - trial;
          qn = {qn[30:0], 1'b1};
        end else begin
          rn = rv;
          qn = {qn[30:0], 1'b0};
        end
        vn = vn << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[k+1]  <= vn;
        rem[k+1]  <= rn;
        root[k+1] <= qn;
      end
    end
  end

  assign root_out = root[NS][30:0];

endmodule

// ----- rtl/core/gcrb_checker.sv -----
// ----------------------------------------------------------------------------
// gcrb_checker: port-level checks for great_circle_range_bearing
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module gcrb_checker #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [25:0] range_out,
  input logic [24:0] bearing_out
);

  // held result keeps its beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_out) && $stable(bearing_out))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // input held back only while results wait in the queue
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (40'(bearing_out) < (40'd360 << ANGLE_FRAC_BITS)))
    else $error("bearing at or beyond a full turn");

endmodule

bind great_circle_range_bearing gcrb_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_gcrb_checker (.*);

// ----- verif/tb_great_circle_range_bearing.sv -----
// ----------------------------------------------------------------------------
// tb_great_circle_range_bearing: self-checking bench for range and bearing
// Drives position pairs through the valid/ready input, predicts the haversine
// range and initial bearing in fixed point, and checks every output beat in
// order. Several earth radius settings, random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_great_circle_range_bearing;

  localparam int FRAC        = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN       = 100;

  class gcrb_scoreboard;
    bit [31:0]   atan_tab [31];
    bit [23:0]   radius;
    gcrb_pkg::result_t due [$];
    int          errors;
    int          shown;

    function new();
      longint unsigned p, total, term, k;
      atan_tab[0] = 32'h2000_0000;
      for (int i = 1; i < 31; i++) begin
        p = 64'd1 << (62 - i);
        total = 0;
        k = 0;
        while (p != 0) begin
          term = p / (2 * k + 1);
          if (k[0] == 1'b0) total += term;
          else total -= term;
          k++;
          p >>= (2 * i);
        end
        atan_tab[i] = (total + 64'd6746518852 / 2) / 64'd6746518852;
      end
      radius = 24'd6371000;
      errors = 0;
      shown = 0;
    endfunction

    function longint mul_q30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function bit [31:0] deg_to_turns(longint v, longint unsigned den);
      longint unsigned m;
      bit [31:0] r;
      m = (v < 0) ? longint'(-v) : v;
      r = ((m << 32) + den / 2) / den;
      return (v < 0) ? -r : r;
    endfunction

    function void rotate(bit [31:0] t, output longint c, output longint s);
      bit flip;
      longint x, y, z, xn, yn;
      flip = (t + 32'h4000_0000) >> 31;
      if (flip) t += 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'($signed(t));
      for (int i = 0; i < 31; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i); yn = y + (x >>> i); z -= atan_tab[i];
        end else begin
          xn = x + (y >>> i); yn = y - (x >>> i); z += atan_tab[i];
        end
        x = xn; y = yn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function bit [31:0] heading(longint x, longint y);
      longint z, xn, yn;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd1 <<< 31;
      end
      for (int i = 0; i < 31; i++) begin
        if (y >= 0) begin
          xn = x + (y >>> i); yn = y - (x >>> i); z += atan_tab[i];
        end else begin
          xn = x - (y >>> i); yn = y + (x >>> i); z -= atan_tab[i];
        end
        x = xn; y = yn;
      end
      return z[31:0];
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b; res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    // work out range and bearing for one accepted pair and queue them
    function void note_pair(logic signed [23:0] la1, logic signed [24:0] lo1,
                            logic signed [23:0] la2, logic signed [24:0] lo2);
      longint unsigned den, hden, asq, bsq, deg;
      longint lat1, lon1, lat2, lon2, c1, s1, c2, s2, cdl, sdl, chl, shl, chn, shn;
      longint a, bx, by;
      bit [31:0] tdlon, half, brg;
      bit [127:0] prod;
      gcrb_pkg::result_t r;
      den = 64'd360 << FRAC;
      hden = 64'd720 << FRAC;
      lat1 = la1; lon1 = lo1; lat2 = la2; lon2 = lo2;
      tdlon = deg_to_turns(lon2 - lon1, den);
      rotate(deg_to_turns(lat1, den), c1, s1);
      rotate(deg_to_turns(lat2, den), c2, s2);
      rotate(tdlon, cdl, sdl);
      rotate(deg_to_turns(lat2 - lat1, hden), chl, shl);
      rotate(deg_to_turns(lon2 - lon1, hden), chn, shn);
      a = mul_q30(shl, shl) + mul_q30(mul_q30(c1, c2), mul_q30(shn, shn));
      if (a < 0) a = 0;
      if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
      asq = root(longint'(a) << 30);
      bsq = root(((64'sd1 <<< 30) - a) << 30);
      half = heading(longint'(bsq), longint'(asq));
      prod = (128'(radius) * 128'(half)) * 128'(64'd13493037705) + (128'd1 << 61);
      prod = prod >> 62;
      r.distance = (prod > 128'd67108863) ? 26'h3FF_FFFF : prod[25:0];
      if (lat1 == lat2 && tdlon == 0) begin
        deg = 0;
      end else begin
        by = mul_q30(sdl, c2);
        bx = mul_q30(c1, s2) - mul_q30(mul_q30(s1, c2), cdl);
        brg = heading(bx, by);
        deg = (longint'(brg) * 360 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        if (deg >= den) deg -= den;
      end
      r.brg = deg[24:0];
      due.push_back(r);
    endfunction

    function void check_result(logic [25:0] rng, logic [24:0] brg);
      gcrb_pkg::result_t e;
      if (due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result beat: range %0d bearing %0d", rng, brg);
        end
        return;
      end
      e = due.pop_front();
      if (rng !== e.distance || brg !== e.brg) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: range exp %0d got %0d, bearing exp %0d got %0d",
                   e.distance, rng, e.brg, brg);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] start_lat = '0;
  logic signed [24:0] start_lon = '0;
  logic signed [23:0] end_lat = '0;
  logic signed [24:0] end_lon = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [25:0]        range_out;
  logic [24:0]        bearing_out;

  gcrb_scoreboard board = new();
  int  cycles = 0;
  int  hold_left = 0;
  bit  burst = 1'b0;

  great_circle_range_bearing #(.ANGLE_FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_lat(start_lat), .start_lon(start_lon),
    .end_lat(end_lat), .end_lon(end_lon),
    .out_valid(out_valid), .out_ready(out_ready),
    .range_out(range_out), .bearing_out(bearing_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: check each beat, idle at random or hold off on request
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) board.check_result(range_out, bearing_out);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= burst || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  task automatic send_pair(logic signed [23:0] la1, logic signed [24:0] lo1,
                           logic signed [23:0] la2, logic signed [24:0] lo2);
    int gap;
    if (!burst && $urandom_range(0, 99) < 19) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_lat <= la1; start_lon <= lo1; end_lat <= la2; end_lon <= lo2;
    do @(posedge clk); while (!in_ready);
    board.note_pair(la1, lo1, la2, lo2);
  endtask

  task automatic send_random();
    logic signed [23:0] la1, la2;
    logic signed [24:0] lo1, lo2;
    if ($urandom_range(0, 99) < 15) begin
      // raw bits: out-of-range angles and every bit of every field
      la1 = 24'($urandom); lo1 = 25'($urandom);
      la2 = 24'($urandom); lo2 = 25'($urandom);
    end else begin
      la1 = 24'(int'($urandom_range(0, 11796480)) - 5898240);
      lo1 = 25'(int'($urandom_range(0, 23592960)) - 11796480);
      if ($urandom_range(0, 3) == 0) begin
        // near neighbour
        la2 = 24'(la1 + int'($urandom_range(0, 2000)) - 1000);
        lo2 = 25'(lo1 + int'($urandom_range(0, 2000)) - 1000);
      end else begin
        la2 = 24'(int'($urandom_range(0, 11796480)) - 5898240);
        lo2 = 25'(int'($urandom_range(0, 23592960)) - 11796480);
      end
    end
    send_pair(la1, lo1, la2, lo2);
  endtask

  // let the pipeline empty, then load a new radius
  task automatic set_radius(logic [23:0] r);
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= r;
    board.radius = r;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [23:0] radii [5];
    radii = '{24'd1, 24'hFF_FFFF, 24'd0, 24'd6371000, 24'd6371000};
    radii[3] = 24'($urandom_range(2, 24'hFF_FFFE));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs under the reset radius
    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, 65536);
    send_pair(0, 0, 65536, 0);
    send_pair(5898240, 0, -5898240, 0);
    send_pair(-5898240, 11796480, 5898240, -11796480);
    send_pair(0, -11796480, 0, 11796480);             // same point across the dateline
    send_pair(1234567, 11796480, 1234567, -11796480);
    send_pair(0, 0, 0, 11796480);                     // antipodal on the equator
    send_pair(3000000, 100000, -3000000, -11696480);  // antipodal
    send_pair(5898240, 0, 5898240, 5000000);          // pole to pole, same
    send_pair(0, 0, -65536, 0);                       // due south
    send_pair(0, 0, 0, -65536);                       // due west
    send_pair(0, 0, 1, -1);                           // tiny step, bearing near 315
    send_pair(0, 0, 100, -1);
    send_pair(24'sh7F_FFFF, 25'sh0FF_FFFF, 24'sh80_0000, 25'sh100_0000);
    send_pair(24'sh80_0000, 25'sh100_0000, 24'sh7F_FFFF, 25'sh0FF_FFFF);
    send_pair(8000000, 0, -8000000, 0);               // latitudes beyond the pole
    send_pair(-1, -1, -1, -1);
    send_pair(2949120, 5898240, -2949120, -5898240);
    send_pair(1, 0, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      set_radius(radii[ph]);
      if (ph == 0) hold_left = 400;   // fill the pipe against a stalled sink
      burst = (ph == 2);
      for (int n = 0; n < 216; n++) send_random();
      burst = 1'b0;
    end

    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
